FILE: rtl/task_scheduler_fcfs_sjf_srtf_unit_assert.svh
// assertion macros for the scheduler rtl
`ifndef TASK_SCHEDULER_FCFS_SJF_SRTF_UNIT_ASSERT_SVH
`define TASK_SCHEDULER_FCFS_SJF_SRTF_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define TSS_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("tss check failed");

// antecedent implies consequent in the next cycle
`define TSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tss check failed");

`endif

FILE: rtl/tss_pkg.sv
package tss_pkg;
   // task status codes
   localparam logic [1:0] ST_UPCOMING   = 2'd0;
   localparam logic [1:0] ST_READY      = 2'd1;
   localparam logic [1:0] ST_RUNNING    = 2'd2;
   localparam logic [1:0] ST_TERMINATED = 2'd3;

   // policy codes
   localparam logic [1:0] POL_FCFS = 2'd0;
   localparam logic [1:0] POL_SJF  = 2'd1;

   // commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // csr indexes
   localparam logic CSR_POLICY    = 1'b0;
   localparam logic CSR_NUM_TASKS = 1'b1;

   // widths wide enough for the largest table
   localparam int IDX_LIM_W = 6;
   localparam int CNT_LIM_W = 7;

   typedef struct packed {
      logic                 push;
      logic                 remove;
      logic [IDX_LIM_W-1:0] idx;
   } fifo_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic [IDX_LIM_W-1:0] head;
      logic [CNT_LIM_W-1:0] count;
   } fifo_stat_type;
endpackage

FILE: rtl/tss_channels.sv
interface tss_req_if #(parameter int TIME_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [3:0]           task_index;
   logic [TIME_BITS-1:0] task_arrival;
   logic [TIME_BITS-1:0] task_work;
   logic [TIME_BITS-1:0] current_time;

   modport source (output valid, command, task_index, task_arrival, task_work,
                   current_time, input ready);
   modport sink (input valid, command, task_index, task_arrival, task_work,
                 current_time, output ready);
endinterface

interface tss_rsp_if;
   logic       valid;
   logic       ready;
   logic       elected_valid;
   logic [3:0] elected_task;
   logic       finished_valid;
   logic [3:0] finished_task;

   modport source (output valid, elected_valid, elected_task, finished_valid,
                   finished_task, input ready);
   modport sink (input valid, elected_valid, elected_task, finished_valid,
                 finished_task, output ready);
endinterface

FILE: rtl/tss_task_mem.sv
module tss_task_mem #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

FILE: rtl/tss_ready_fifo.sv
module tss_ready_fifo #(
   parameter int MAX_TASKS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tss_pkg::fifo_cmd_type  cmd,
   output tss_pkg::fifo_stat_type stat
);
   import tss_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   logic [IDX_W-1:0] slot_ff [MAX_TASKS];
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic [CNT_W-1:0] rd_ff;
   logic [CNT_W-1:0] wr_ff;
   logic [IDX_W-1:0] key_ff;

   // push appends, remove compacts the queue one slot a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else if (busy_ff) begin
         if (rd_ff < count_ff) begin
            if (slot_ff[rd_ff[IDX_W-1:0]] != key_ff) begin
               slot_ff[wr_ff[IDX_W-1:0]] <= slot_ff[rd_ff[IDX_W-1:0]];
               wr_ff <= wr_ff + 1'b1;
            end
            rd_ff <= rd_ff + 1'b1;
         end else begin
            count_ff <= wr_ff;
            busy_ff  <= 1'b0;
         end
      end else if (cmd.remove) begin
         busy_ff <= 1'b1;
         rd_ff   <= '0;
         wr_ff   <= '0;
         key_ff  <= IDX_W'(cmd.idx);
      end else if (cmd.push && (32'(count_ff) < MAX_TASKS)) begin
         slot_ff[count_ff[IDX_W-1:0]] <= IDX_W'(cmd.idx);
         count_ff <= count_ff + 1'b1;
      end
   end

   assign stat.busy  = busy_ff;
   assign stat.head  = IDX_LIM_W'(slot_ff[0]);
   assign stat.count = CNT_LIM_W'(count_ff);
endmodule

FILE: rtl/task_scheduler_fcfs_sjf_srtf_unit.sv
// channel | dir | beat contents
// req_ch  | in  | command, task_index, task_arrival, task_work, current_time
// rsp_ch  | out | elected_valid/task, finished_valid/task
// csr     | in  | csr_wen, csr_index, csr_wdata (policy, num_tasks)
// a tick beat does one table memory read per entry in the admission and election
// scan, then one read-modify-write of the winner. a terminating task or a load adds
// a ready queue compaction. one beat is worked on at a time; a result waiting in
// rsp does not block the next beat until that one is done. reset is synchronous;
// the table memory is not cleared.
module task_scheduler_fcfs_sjf_srtf_unit #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   tss_req_if.sink    req_ch,
   tss_rsp_if.source  rsp_ch,
   input  logic       csr_wen,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata
);
   import tss_pkg::*;
   `include "task_scheduler_fcfs_sjf_srtf_unit_assert.svh"

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int TB    = TIME_BITS;
   localparam int MW    = 3 * TIME_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_SEL  = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       pol_ff, pol_in;
   logic [4:0]       ntask_ff, ntask_in;
   logic [1:0]       status_ff [MAX_TASKS];
   logic [1:0]       status_in [MAX_TASKS];
   logic             run_valid_ff, run_valid_in;
   logic [IDX_W-1:0] runner_ff, runner_in;
   logic [TB-1:0]    now_ff, now_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [TB-1:0]    best_ff, best_in;
   logic             best_ok_ff, best_ok_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic             first_ff, first_in;
   logic             head_after_ff, head_after_in;
   logic             res_ev_ff, res_ev_in;
   logic [3:0]       res_e_ff, res_e_in;
   logic             res_fv_ff, res_fv_in;
   logic [3:0]       res_f_ff, res_f_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ev_ff, rsp_fv_ff;
   logic [3:0]       rsp_e_ff, rsp_f_ff;

   logic             mem_rd_en, mem_wr_en;
   logic [IDX_W-1:0] mem_rd_addr, mem_wr_addr;
   logic [MW-1:0]    mem_rd_data, mem_wr_data;
   fifo_cmd_type     fcmd;
   fifo_stat_type    fstat;

   logic             req_fire;
   logic [IDX_W-1:0] load_idx;
   logic             load_ok;
   logic [CNT_W-1:0] n_used;
   logic [TB-1:0]    m_arr, m_need, m_done, done_inc, key;
   logic [1:0]       st, st2;
   logic             adm, cand, fcfs, term_first;

   tss_task_mem #(.WIDTH(MW), .DEPTH(MAX_TASKS)) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   tss_ready_fifo #(.MAX_TASKS(MAX_TASKS)) u_fifo (
      .clock (clock),
      .reset (reset),
      .cmd   (fcmd),
      .stat  (fstat)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign load_idx     = IDX_W'(req_ch.task_index);
   assign load_ok      = 32'(req_ch.task_index) < MAX_TASKS;
   assign n_used       = (32'(ntask_ff) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(ntask_ff);
   assign fcfs         = (pol_ff == POL_FCFS);

   // fields of the registered table word
   assign m_arr    = mem_rd_data[MW-1:2*TB];
   assign m_need   = mem_rd_data[2*TB-1:TB];
   assign m_done   = mem_rd_data[TB-1:0];
   assign done_inc = (m_done != {TB{1'b1}}) ? m_done + 1'b1 : m_done;

   // admission and candidate check of the scanned entry
   always_comb begin
      st   = status_ff[chk_idx_ff];
      adm  = (st == ST_UPCOMING) && (m_arr == now_ff);
      st2  = adm ? ST_READY : st;
      if (pol_ff == POL_SJF) begin
         cand = (st2 == ST_READY);
         key  = m_need;
      end else begin
         cand = (st2 == ST_READY) || (st2 == ST_RUNNING);
         key  = (m_done >= m_need) ? '0 : m_need - m_done;
      end
   end

   assign term_first = fcfs && first_ff && (status_ff[sel_ff] == ST_RUNNING) &&
                       (m_done >= m_need);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pol_in        = pol_ff;
      ntask_in      = ntask_ff;
      status_in     = status_ff;
      run_valid_in  = run_valid_ff;
      runner_in     = runner_ff;
      now_in        = now_ff;
      cnt_in        = cnt_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      best_in       = best_ff;
      best_ok_in    = best_ok_ff;
      best_idx_in   = best_idx_ff;
      sel_in        = sel_ff;
      first_in      = first_ff;
      head_after_in = head_after_ff;
      res_ev_in     = res_ev_ff;
      res_e_in      = res_e_ff;
      res_fv_in     = res_fv_ff;
      res_f_in      = res_f_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      fcmd          = '0;

      // register writes
      if (csr_wen) begin
         unique case (csr_index)
            CSR_POLICY:    pol_in   = csr_wdata[1:0];
            CSR_NUM_TASKS: ntask_in = csr_wdata;
            default:       ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_ev_in     = 1'b0;
               res_e_in      = '0;
               res_fv_in     = 1'b0;
               res_f_in      = '0;
               head_after_in = 1'b0;
               if (req_ch.command == CMD_LOAD) begin
                  if (load_ok) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = load_idx;
                     mem_wr_data = {req_ch.task_arrival, req_ch.task_work, {TB{1'b0}}};
                     status_in[load_idx] = ST_UPCOMING;
                     if (run_valid_ff && runner_ff == load_idx) begin
                        run_valid_in = 1'b0;
                     end
                     fcmd.remove = 1'b1;
                     fcmd.idx    = IDX_LIM_W'(load_idx);
                     state_in    = S_WAIT;
                  end else begin
                     state_in = S_OUT;
                  end
               end else begin
                  now_in     = req_ch.current_time;
                  cnt_in     = '0;
                  chk_in     = 1'b0;
                  best_ok_in = 1'b0;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read one entry a cycle, check the one read last cycle
            chk_in     = cnt_ff < n_used;
            chk_idx_in = cnt_ff[IDX_W-1:0];
            if (cnt_ff < n_used) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end
            if (chk_ff) begin
               if (adm) begin
                  status_in[chk_idx_ff] = ST_READY;
                  fcmd.push = 1'b1;
                  fcmd.idx  = IDX_LIM_W'(chk_idx_ff);
               end
               if (cand && (!best_ok_ff || key < best_ff)) begin
                  best_in     = key;
                  best_ok_in  = 1'b1;
                  best_idx_in = chk_idx_ff;
               end
            end
            if (!(cnt_ff < n_used) && !chk_ff) begin
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            first_in = 1'b1;
            priority if (fcfs) begin
               if (fstat.count == '0) begin
                  state_in = S_OUT;
               end else begin
                  sel_in   = IDX_W'(fstat.head);
                  state_in = S_EXEC;
               end
            end else if (pol_ff == POL_SJF && run_valid_ff &&
                         status_ff[runner_ff] == ST_RUNNING) begin
               sel_in   = runner_ff;
               state_in = S_EXEC;
            end else if (best_ok_ff) begin
               sel_in   = best_idx_ff;
               state_in = S_EXEC;
            end else begin
               state_in = S_OUT;
            end
            mem_rd_en   = (state_in == S_EXEC);
            mem_rd_addr = sel_in;
         end
         S_EXEC: begin
            if (term_first) begin
               // finished fcfs head leaves at the start of this tick
               status_in[sel_ff] = ST_TERMINATED;
               if (run_valid_ff && runner_ff == sel_ff) begin
                  run_valid_in = 1'b0;
               end
               fcmd.remove   = 1'b1;
               fcmd.idx      = IDX_LIM_W'(sel_ff);
               res_fv_in     = 1'b1;
               res_f_in      = 4'(sel_ff);
               head_after_in = 1'b1;
               state_in      = S_WAIT;
            end else begin
               // run one unit, preempting another runner
               if (run_valid_ff && runner_ff != sel_ff &&
                   status_ff[runner_ff] == ST_RUNNING) begin
                  status_in[runner_ff] = ST_READY;
               end
               status_in[sel_ff] = ST_RUNNING;
               run_valid_in      = 1'b1;
               runner_in         = sel_ff;
               mem_wr_en         = 1'b1;
               mem_wr_addr       = sel_ff;
               mem_wr_data       = {m_arr, m_need, done_inc};
               res_ev_in         = 1'b1;
               res_e_in          = 4'(sel_ff);
               head_after_in     = 1'b0;
               state_in          = S_OUT;
               if (!fcfs && done_inc >= m_need) begin
                  status_in[sel_ff] = ST_TERMINATED;
                  run_valid_in      = 1'b0;
                  fcmd.remove       = 1'b1;
                  fcmd.idx          = IDX_LIM_W'(sel_ff);
                  res_fv_in         = 1'b1;
                  res_f_in          = 4'(sel_ff);
                  state_in          = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (!fstat.busy) begin
               if (head_after_ff && fstat.count != '0) begin
                  sel_in      = IDX_W'(fstat.head);
                  first_in    = 1'b0;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = IDX_W'(fstat.head);
                  state_in    = S_EXEC;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pol_ff       <= POL_FCFS;
         ntask_ff     <= '0;
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            status_ff[i] <= ST_UPCOMING;
         end
      end else begin
         state_ff     <= state_in;
         pol_ff       <= pol_in;
         ntask_ff     <= ntask_in;
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
         status_ff    <= status_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      runner_ff     <= runner_in;
      now_ff        <= now_in;
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      best_ff       <= best_in;
      best_ok_ff    <= best_ok_in;
      best_idx_ff   <= best_idx_in;
      sel_ff        <= sel_in;
      first_ff      <= first_in;
      head_after_ff <= head_after_in;
      res_ev_ff     <= res_ev_in;
      res_e_ff      <= res_e_in;
      res_fv_ff     <= res_fv_in;
      res_f_ff      <= res_f_in;
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_ev_ff <= res_ev_ff;
         rsp_e_ff  <= res_e_ff;
         rsp_fv_ff <= res_fv_ff;
         rsp_f_ff  <= res_f_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.elected_valid  = rsp_ev_ff;
   assign rsp_ch.elected_task   = rsp_e_ff;
   assign rsp_ch.finished_valid = rsp_fv_ff;
   assign rsp_ch.finished_task  = rsp_f_ff;

   // checks
   `TSS_ASSERT_NEVER(a_runner_running, run_valid_ff && status_ff[runner_ff] != ST_RUNNING)
   `TSS_ASSERT_NEVER(a_fifo_bound, 32'(fstat.count) > MAX_TASKS)
   `TSS_ASSERT_NEXT(a_tick_scans, req_fire && req_ch.command == CMD_TICK, state_ff == S_SCAN)
endmodule

FILE: tb/task_scheduler_fcfs_sjf_srtf_unit_test.sv
module task_scheduler_fcfs_sjf_srtf_unit_test;
   import tss_pkg::*;

   typedef struct {
      logic        command;
      logic [3:0]  index;
      logic [15:0] arrival;
      logic [15:0] work;
      logic [15:0] now;
   } sched_beat_type;

   typedef struct {
      logic       elected_valid;
      logic [3:0] elected_task;
      logic       finished_valid;
      logic [3:0] finished_task;
   } sched_result_type;

   localparam int DRAIN_CYCLES = 64;

   logic       clock;
   logic       reset;
   logic       csr_wen;
   logic       csr_index;
   logic [4:0] csr_wdata;

   tss_req_if #(.TIME_BITS(16)) req_ch();
   tss_rsp_if rsp_ch();

   task_scheduler_fcfs_sjf_srtf_unit uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // scheduler mirror state
   logic [1:0]  task_state [16];
   logic [15:0] arrival_tick [16];
   logic [15:0] work_total [16];
   logic [15:0] work_spent [16];
   logic [3:0]  ready_line [16];
   int          ready_count;
   bit          runner_live;
   int          runner_idx;
   logic [1:0]  sched_policy;
   logic [4:0]  table_size;

   sched_result_type pending_results [$];
   int          fail_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   logic [15:0] tick_clock;

   always #2 clock = ~clock;

   // mirror helpers
   function automatic void ready_line_drop(int idx);
      int w;
      w = 0;
      for (int r = 0; r < ready_count; r++) begin
         if (ready_line[r] != idx) begin
            ready_line[w] = ready_line[r];
            w++;
         end
      end
      ready_count = w;
   endfunction

   function automatic void dispatch(int idx);
      if (runner_live && runner_idx != idx && task_state[runner_idx] == ST_RUNNING) begin
         task_state[runner_idx] = ST_READY;
      end
      if (work_spent[idx] != 16'hFFFF) work_spent[idx]++;
      task_state[idx] = ST_RUNNING;
      runner_live = 1;
      runner_idx = idx;
   endfunction

   function automatic void retire(int idx);
      task_state[idx] = ST_TERMINATED;
      ready_line_drop(idx);
      if (runner_live && runner_idx == idx) runner_live = 0;
   endfunction

   function automatic sched_result_type schedule_beat(sched_beat_type b);
      sched_result_type res;
      int used, elected, finished, idx;
      logic [15:0] best, key;
      bit cand;
      res = '{1'b0, 4'd0, 1'b0, 4'd0};
      elected = -1;
      finished = -1;
      // load: fresh entry, pulled out of the queue and off the cpu
      if (b.command == CMD_LOAD) begin
         arrival_tick[b.index] = b.arrival;
         work_total[b.index] = b.work;
         work_spent[b.index] = '0;
         task_state[b.index] = ST_UPCOMING;
         ready_line_drop(b.index);
         if (runner_live && runner_idx == b.index) runner_live = 0;
         return res;
      end
      used = (table_size > 16) ? 16 : table_size;
      // admission in index order
      for (int i = 0; i < used; i++) begin
         if (task_state[i] == ST_UPCOMING && arrival_tick[i] == b.now) begin
            task_state[i] = ST_READY;
            if (ready_count < 16) begin
               ready_line[ready_count] = 4'(i);
               ready_count++;
            end
         end
      end
      if (sched_policy == POL_FCFS) begin
         // head finishes at the start of the tick after its last unit
         if (ready_count > 0) begin
            idx = ready_line[0];
            if (task_state[idx] == ST_RUNNING) begin
               if (work_spent[idx] >= work_total[idx]) begin
                  retire(idx);
                  finished = idx;
               end else begin
                  dispatch(idx);
                  elected = idx;
               end
            end
         end
         if (elected < 0 && ready_count > 0) begin
            idx = ready_line[0];
            dispatch(idx);
            elected = idx;
         end
      end else begin
         if (sched_policy == POL_SJF && runner_live
               && task_state[runner_idx] == ST_RUNNING) begin
            elected = runner_idx;
         end else begin
            best = '0;
            for (int i = 0; i < used; i++) begin
               if (sched_policy == POL_SJF) begin
                  cand = (task_state[i] == ST_READY);
                  key = work_total[i];
               end else begin
                  cand = (task_state[i] == ST_READY || task_state[i] == ST_RUNNING);
                  key = (work_spent[i] >= work_total[i]) ? 16'd0
                        : work_total[i] - work_spent[i];
               end
               if (cand && (elected < 0 || key < best)) begin
                  best = key;
                  elected = i;
               end
            end
         end
         if (elected >= 0) begin
            dispatch(elected);
            if (work_spent[elected] >= work_total[elected]) begin
               retire(elected);
               finished = elected;
            end
         end
      end
      if (elected >= 0) begin
         res.elected_valid = 1;
         res.elected_task = 4'(elected);
      end
      if (finished >= 0) begin
         res.finished_valid = 1;
         res.finished_task = 4'(finished);
      end
      return res;
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.elected_valid !== want.elected_valid) begin
               $error("elected_valid exp %0d got %0d", want.elected_valid, rsp_ch.elected_valid);
               fail_count++;
            end
            if (rsp_ch.elected_task !== want.elected_task) begin
               $error("elected_task exp %0d got %0d", want.elected_task, rsp_ch.elected_task);
               fail_count++;
            end
            if (rsp_ch.finished_valid !== want.finished_valid) begin
               $error("finished_valid exp %0d got %0d", want.finished_valid,
                      rsp_ch.finished_valid);
               fail_count++;
            end
            if (rsp_ch.finished_task !== want.finished_task) begin
               $error("finished_task exp %0d got %0d", want.finished_task, rsp_ch.finished_task);
               fail_count++;
            end
         end
      end
   end

   // send one beat; valid stays high unless the next call idles
   task automatic send_beat(sched_beat_type b);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1;
      req_ch.command <= b.command;
      req_ch.task_index <= b.index;
      req_ch.task_arrival <= b.arrival;
      req_ch.task_work <= b.work;
      req_ch.current_time <= b.now;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(schedule_beat(b));
   endtask

   task automatic send_load(logic [3:0] idx, logic [15:0] arr, logic [15:0] work);
      send_beat('{CMD_LOAD, idx, arr, work, 16'($urandom)});
   endtask

   task automatic send_tick(logic [15:0] now);
      send_beat('{CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom), now});
   endtask

   // wait until the block is quiet
   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] value);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 0;
      if (idx == CSR_POLICY) sched_policy = value[1:0];
      else table_size = value;
      @(posedge clock);
   endtask

   // extremes, every entry loaded, fcfs start and finish
   task automatic test_directed();
      write_csr(CSR_POLICY, 5'(POL_FCFS));
      write_csr(CSR_NUM_TASKS, 5'd4);
      for (int i = 0; i < 16; i++) send_load(4'(i), 16'(i % 3), 16'(1 + i % 2));
      send_load(4'd15, 16'hFFFF, 16'hFFFF);
      send_load(4'd3, 16'hFFFF, 16'hFFFF);
      send_load(4'd2, 16'h0000, 16'h5555);
      for (int t = 0; t < 5; t++) send_tick(16'(t));
      send_load(4'd0, 16'h0005, 16'h0001);
      send_tick(16'h0005);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      drain();
   endtask

   // one policy and table size under one idling mode
   task automatic test_workload(logic [4:0] pol, logic [4:0] count, int rounds,
                                int idle_pct, int stall_pct);
      int used;
      int nload;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      write_csr(CSR_POLICY, pol);
      write_csr(CSR_NUM_TASKS, count);
      used = (count > 16) ? 16 : count;
      for (int r = 0; r < rounds; r++) begin
         // a batch of tasks arriving soon, then a run of consecutive ticks
         nload = $urandom_range(2, 8);
         for (int k = 0; k < nload; k++) begin
            send_load(4'($urandom_range(used == 0 ? 15 : used - 1)),
                      ($urandom_range(19) == 0) ? 16'($urandom)
                         : tick_clock + 16'($urandom_range(6)),
                      ($urandom_range(19) == 0) ? 16'($urandom_range(1, 65535))
                         : 16'($urandom_range(1, 6)));
         end
         for (int t = 0; t < 16; t++) begin
            if ($urandom_range(14) == 0) begin
               send_load(4'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
            end else if ($urandom_range(19) == 0) begin
               send_tick(16'($urandom));
            end else begin
               send_tick(tick_clock);
               tick_clock++;
            end
         end
         if (r == rounds / 2) drain();
      end
      drain();
   endtask

   initial begin
      logic [4:0] sizes [5];
      clock = 0;
      reset = 1;
      csr_wen = 0;
      csr_index = CSR_POLICY;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.command = CMD_LOAD;
      req_ch.task_index = '0;
      req_ch.task_arrival = '0;
      req_ch.task_work = '0;
      req_ch.current_time = '0;
      fail_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      tick_clock = 16'd100;
      for (int i = 0; i < 16; i++) begin
         task_state[i] = ST_UPCOMING;
         work_spent[i] = '0;
      end
      ready_count = 0;
      runner_live = 0;
      runner_idx = 0;
      sched_policy = POL_FCFS;
      table_size = '0;
      sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_directed();
      for (int p = 0; p < 16; p++) begin
         int idle_pct, stall_pct;
         case (p / 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 17; stall_pct = 17; end
         endcase
         test_workload(5'(p % 4), (p % 5 == 4) ? 5'($urandom_range(2, 15)) : sizes[p % 5],
                       3, idle_pct, stall_pct);
      end

      if (fail_count == 0) begin
         $display("[task_scheduler_fcfs_sjf_srtf_unit] OK");
      end else begin
         $display("[task_scheduler_fcfs_sjf_srtf_unit] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("[task_scheduler_fcfs_sjf_srtf_unit] ERROR");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_channels.sv
rtl/tss_task_mem.sv
rtl/tss_ready_fifo.sv
rtl/task_scheduler_fcfs_sjf_srtf_unit.sv
tb/task_scheduler_fcfs_sjf_srtf_unit_test.sv
